// ===== hdl/uv_sphere_vertex_generator_top_assert.svh =====
// assertion macros for the uv sphere vertex generator
// depends on a clock named clock and a reset named reset in the using module
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_ASSERT_SVH

// property holds at every edge outside reset
`define UVS_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("uvs check failed");

// property holds at the edge after the trigger
`define UVS_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("uvs check failed");

`endif

// ===== hdl/uvs_pkg.sv =====
// shared constants and arithmetic helpers for the uv sphere vertex generator
// no dependencies
`default_nettype none
package uvs_pkg;

   localparam int MAX_DIVISIONS = 1024;
   localparam int CORDIC_STAGES = 16;
   localparam int DIV_STEPS     = 33;
   localparam int PIPE_DEPTH    = 1 + DIV_STEPS + CORDIC_STAGES + 4;

   localparam logic [2:0] CSR_POLAR_DIV   = 3'd0;
   localparam logic [2:0] CSR_AZIMUTH_DIV = 3'd1;
   localparam logic [2:0] CSR_RADIUS      = 3'd2;
   localparam logic [2:0] CSR_CENTER_X    = 3'd3;
   localparam logic [2:0] CSR_CENTER_Y    = 3'd4;

   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

   localparam logic [31:0] ATAN_TURN [0:31] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   function automatic logic [31:0] atan_at(input logic [4:0] idx);
      return ATAN_TURN[idx];
   endfunction

   // effective divisions: zero acts as one, clipped to the maximum
   function automatic logic [10:0] eff_div(input logic [10:0] d);
      if (d == 11'd0) return 11'd1;
      if (d > 11'(MAX_DIVISIONS)) return 11'(MAX_DIVISIONS);
      return d;
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [34:0] v);
      logic signed [35:0] t;
      logic signed [20:0] q;
      t = 36'(v) + 36'sd16384;
      q = t[35:15];
      if (q > 21'sd32767) return 16'sd32767;
      if (q < -21'sd32768) return -16'sd32768;
      return q[15:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) return 32'sh7fffffff;
      if (v < -35'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // quadrant fold and rounding, result is {cos, sin}
   function automatic logic [31:0] fold_cs(input logic [1:0] quad,
                                           input logic signed [33:0] x,
                                           input logic signed [33:0] y);
      logic signed [34:0] ex;
      logic signed [34:0] ey;
      logic signed [34:0] c;
      logic signed [34:0] s;
      ex = 35'(x);
      ey = 35'(y);
      case (quad)
         2'd0: begin c = ex;  s = ey;  end
         2'd1: begin c = -ey; s = ex;  end
         2'd2: begin c = -ex; s = -ey; end
         default: begin c = ey; s = -ex; end
      endcase
      return {to_q15(c), to_q15(s)};
   endfunction

endpackage
`default_nettype wire

// ===== hdl/uvs_div_cell.sv =====
// one restoring division step, registered
// depends on nothing but its ports
`default_nettype none
module uvs_div_cell (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [10:0] rem_i,
   input  wire logic [32:0] num_i,
   input  wire logic [32:0] quo_i,
   input  wire logic [10:0] div_i,
   output logic      [10:0] rem_o,
   output logic      [32:0] num_o,
   output logic      [32:0] quo_o,
   output logic      [10:0] div_o
);
   logic [10:0] rem_ff, rem_in;
   logic [32:0] num_ff, quo_ff;
   logic [10:0] div_ff;
   logic [11:0] trial;
   logic        fits;

   always_comb begin
      trial  = {rem_i, num_i[32]};
      fits   = trial >= {1'b0, div_i};
      rem_in = fits ? 11'(trial - {1'b0, div_i}) : trial[10:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff <= rem_in;
         num_ff <= {num_i[31:0], 1'b0};
         quo_ff <= {quo_i[31:0], fits};
         div_ff <= div_i;
      end
   end

   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign quo_o = quo_ff;
   assign div_o = div_ff;
endmodule
`default_nettype wire

// ===== hdl/uvs_cordic_cell.sv =====
// one rotation-mode cordic micro-rotation, registered
// depends on uvs_pkg for the arctangent table
`default_nettype none
module uvs_cordic_cell (
   input  wire logic               clock,
   input  wire logic               adv,
   input  wire logic        [4:0]  idx,
   input  wire logic signed [33:0] x_i,
   input  wire logic signed [33:0] y_i,
   input  wire logic signed [32:0] z_i,
   input  wire logic        [1:0]  quad_i,
   output logic signed      [33:0] x_o,
   output logic signed      [33:0] y_o,
   output logic signed      [32:0] z_o,
   output logic             [1:0]  quad_o
);
   logic signed [33:0] x_ff, y_ff, x_in, y_in, dx, dy;
   logic signed [32:0] z_ff, z_in, at;
   logic        [1:0]  quad_ff;

   always_comb begin
      dx = y_i >>> idx;
      dy = x_i >>> idx;
      at = $signed({1'b0, uvs_pkg::atan_at(idx)});
      if (!z_i[32]) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - at;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + at;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         quad_ff <= quad_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign quad_o = quad_ff;
endmodule
`default_nettype wire

// ===== hdl/uv_sphere_vertex_generator_top.sv =====
// uv sphere vertex generator: grid step pair in, translated vertex out
// depends on uvs_pkg, uvs_div_cell, uvs_cordic_cell and the assertion header
//
//   channel  | direction | ports
//   ---------+-----------+-----------------------------------------------
//   req      | in        | req_valid, req_stall, req_polar_step, req_azimuth_step
//   rsp      | out       | rsp_valid, rsp_stall, rsp_vertex_x/_y/_z, rsp_step_clamped
//   csr      | in        | csr_wr_en, csr_index, csr_wdata
//
// one request per cycle unless stalled, through 54 register stages: 1 input stage, 33 long-division
// cells, 16 cordic cells, 4 stages of fold, products and rounding
// a result is valid once its request has passed through all of these stages
// synchronous active-high reset clears valid bits and loads register defaults
// the whole pipeline moves when the output register is empty or being taken,
// so req_stall follows rsp_stall while a result is held
`default_nettype none
`include "uv_sphere_vertex_generator_top_assert.svh"
module uv_sphere_vertex_generator_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [10:0] req_polar_step,
   input  wire logic        [10:0] req_azimuth_step,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed      [31:0] rsp_vertex_x,
   output logic signed      [31:0] rsp_vertex_y,
   output logic signed      [31:0] rsp_vertex_z,
   output logic                    rsp_step_clamped,
   input  wire logic               csr_wr_en,
   input  wire logic        [2:0]  csr_index,
   input  wire logic        [31:0] csr_wdata
);
   localparam int D  = uvs_pkg::PIPE_DEPTH;
   localparam int NS = uvs_pkg::DIV_STEPS;
   localparam int NC = uvs_pkg::CORDIC_STAGES;

   // configuration registers
   logic        [10:0] pdiv_ff, adiv_ff;
   logic        [30:0] radius_ff;
   logic signed [31:0] cx_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pdiv_ff   <= 11'd100;
         adiv_ff   <= 11'd100;
         radius_ff <= 31'd256;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            uvs_pkg::CSR_POLAR_DIV:   pdiv_ff   <= csr_wdata[10:0];
            uvs_pkg::CSR_AZIMUTH_DIV: adiv_ff   <= csr_wdata[10:0];
            uvs_pkg::CSR_RADIUS:      radius_ff <= csr_wdata[30:0];
            uvs_pkg::CSR_CENTER_X:    cx_ff     <= csr_wdata;
            uvs_pkg::CSR_CENTER_Y:    cy_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline advance: output register free or being drained
   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // valid and clamp flag ride alongside the datapath
   logic [D-1:0] vld_ff, vld_in, clp_ff, clp_in;
   logic         clp_req;
   logic [10:0]  pd_eff, ad_eff;

   always_comb begin
      pd_eff  = uvs_pkg::eff_div(pdiv_ff);
      ad_eff  = uvs_pkg::eff_div(adiv_ff);
      clp_req = (req_polar_step > pd_eff) || (req_azimuth_step > ad_eff);
      vld_in  = {vld_ff[D-2:0], req_valid};
      clp_in  = {clp_ff[D-2:0], clp_req};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         clp_ff <= clp_in;
      end
   end

   // input stage: clamped steps and effective divisions
   logic [10:0] ps0_ff, as0_ff, pd0_ff, ad0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ps0_ff <= (req_polar_step > pd_eff) ? pd_eff : req_polar_step;
         as0_ff <= (req_azimuth_step > ad_eff) ? ad_eff : req_azimuth_step;
         pd0_ff <= pd_eff;
         ad0_ff <= ad_eff;
      end
   end

   // dividends with half-divisor rounding; the top ten bits are already
   // below the divisor, so the chain only produces the low 33 quotient bits
   logic [42:0] pnum, anum;
   assign pnum = (43'(ps0_ff) << 31) + 43'(pd0_ff >> 1);
   assign anum = (43'(as0_ff) << 32) + 43'(ad0_ff >> 1);

   logic [10:0] prem [0:NS];
   logic [32:0] pnm  [0:NS];
   logic [32:0] pquo [0:NS];
   logic [10:0] pdv  [0:NS];
   logic [10:0] arem [0:NS];
   logic [32:0] anm  [0:NS];
   logic [32:0] aquo [0:NS];
   logic [10:0] adv_d [0:NS];

   assign prem[0]  = {1'b0, pnum[42:33]};
   assign pnm[0]   = pnum[32:0];
   assign pquo[0]  = '0;
   assign pdv[0]   = pd0_ff;
   assign arem[0]  = {1'b0, anum[42:33]};
   assign anm[0]   = anum[32:0];
   assign aquo[0]  = '0;
   assign adv_d[0] = ad0_ff;

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_div
         uvs_div_cell u_pdiv (
            .clock (clock), .adv (adv),
            .rem_i (prem[k]), .num_i (pnm[k]), .quo_i (pquo[k]), .div_i (pdv[k]),
            .rem_o (prem[k+1]), .num_o (pnm[k+1]), .quo_o (pquo[k+1]),
            .div_o (pdv[k+1])
         );
         uvs_div_cell u_adiv (
            .clock (clock), .adv (adv),
            .rem_i (arem[k]), .num_i (anm[k]), .quo_i (aquo[k]), .div_i (adv_d[k]),
            .rem_o (arem[k+1]), .num_o (anm[k+1]), .quo_o (aquo[k+1]),
            .div_o (adv_d[k+1])
         );
      end
   endgenerate

   // cordic chains: quadrant from the top two turn bits, rest rotated
   logic signed [33:0] px [0:NC];
   logic signed [33:0] py [0:NC];
   logic signed [32:0] pz [0:NC];
   logic        [1:0]  pq [0:NC];
   logic signed [33:0] ax [0:NC];
   logic signed [33:0] ay [0:NC];
   logic signed [32:0] az [0:NC];
   logic        [1:0]  aq [0:NC];

   assign px[0] = uvs_pkg::GAIN_Q30;
   assign py[0] = '0;
   assign pz[0] = $signed({3'b000, pquo[NS][29:0]});
   assign pq[0] = pquo[NS][31:30];
   assign ax[0] = uvs_pkg::GAIN_Q30;
   assign ay[0] = '0;
   assign az[0] = $signed({3'b000, aquo[NS][29:0]});
   assign aq[0] = aquo[NS][31:30];

   genvar j;
   generate
      for (j = 0; j < NC; j++) begin : g_cordic
         uvs_cordic_cell u_pcor (
            .clock (clock), .adv (adv), .idx (5'(j)),
            .x_i (px[j]), .y_i (py[j]), .z_i (pz[j]), .quad_i (pq[j]),
            .x_o (px[j+1]), .y_o (py[j+1]), .z_o (pz[j+1]), .quad_o (pq[j+1])
         );
         uvs_cordic_cell u_acor (
            .clock (clock), .adv (adv), .idx (5'(j)),
            .x_i (ax[j]), .y_i (ay[j]), .z_i (az[j]), .quad_i (aq[j]),
            .x_o (ax[j+1]), .y_o (ay[j+1]), .z_o (az[j+1]), .quad_o (aq[j+1])
         );
      end
   endgenerate

   // fold into Q1.15 cos and sin
   logic signed [15:0] cp_ff, sp_ff, ct_ff, st_ff;
   logic [31:0] pcs, acs;
   assign pcs = uvs_pkg::fold_cs(pq[NC], px[NC], py[NC]);
   assign acs = uvs_pkg::fold_cs(aq[NC], ax[NC], ay[NC]);

   always_ff @(posedge clock) begin
      if (adv) begin
         cp_ff <= $signed(pcs[31:16]);
         sp_ff <= $signed(pcs[15:0]);
         ct_ff <= $signed(acs[31:16]);
         st_ff <= $signed(acs[15:0]);
      end
   end

   // trig products
   logic signed [31:0] spct_ff, spst_ff;
   logic signed [15:0] cp2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         spct_ff <= sp_ff * ct_ff;
         spst_ff <= sp_ff * st_ff;
         cp2_ff  <= cp_ff;
      end
   end

   // radius products
   logic signed [63:0] mx_ff, my_ff;
   logic signed [47:0] mz_ff;
   logic signed [31:0] rad_s;
   assign rad_s = $signed({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= 64'(rad_s) * 64'(spct_ff);
         my_ff <= 64'(rad_s) * 64'(spst_ff);
         mz_ff <= 48'(rad_s) * 48'(cp2_ff);
      end
   end

   // rounding, translation and saturation into the output register
   // the shifted products are signed, so they sign extend
   logic signed [63:0] rx, ry;
   logic signed [47:0] rz;
   logic signed [34:0] sx, sy, sz;

   always_comb begin
      rx = mx_ff + 64'sd536870912;
      ry = my_ff + 64'sd536870912;
      rz = mz_ff + 48'sd16384;
      sx = 35'($signed(rx[63:30])) + 35'(cx_ff);
      sy = 35'($signed(ry[63:30])) + 35'(cy_ff);
      sz = 35'($signed(rz[47:15]));
   end

   logic signed [31:0] vx_ff, vy_ff, vz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff <= uvs_pkg::sat32(sx);
         vy_ff <= uvs_pkg::sat32(sy);
         vz_ff <= uvs_pkg::sat32(sz);
      end
   end

   assign rsp_valid        = vld_ff[D-1];
   assign rsp_step_clamped = clp_ff[D-1];
   assign rsp_vertex_x     = vx_ff;
   assign rsp_vertex_y     = vy_ff;
   assign rsp_vertex_z     = vz_ff;

   // a stalled pipeline keeps all of its valid bits
   `UVS_ASSERT_NEXT(a_hold_valid, !adv, $stable(vld_ff))
   // input stage never carries a step beyond its divisions
   `UVS_ASSERT_NOW(a_step_range, vld_ff[0], (ps0_ff <= pd0_ff) && (as0_ff <= ad0_ff))
   // effective divisions are never zero
   `UVS_ASSERT_NOW(a_div_nonzero, vld_ff[0], (pd0_ff != 11'd0) && (ad0_ff != 11'd0))
endmodule
`default_nettype wire
